// ----- rtl/qicf_pkg.sv -----
// Shared constants for the quadratic irrational continued fraction block.
`default_nettype none
package qicf_pkg;
  localparam int MAX_TERMS_DEF = 64;
  localparam int IDX_W         = 7;
  localparam int IN_W          = 56;
  localparam int OUT_W         = 48;
  localparam int ST_W          = 2;
  localparam int RAD_W         = 56;
  localparam int ROOT_W        = 28;

  localparam logic [ST_W-1:0] STAT_OK       = 2'd0;
  localparam logic [ST_W-1:0] STAT_ZERO_DEN = 2'd1;
  localparam logic [ST_W-1:0] STAT_BAD_RAD  = 2'd2;
  localparam logic [ST_W-1:0] STAT_OVERFLOW = 2'd3;
endpackage
`default_nettype wire

// ----- rtl/quadratic_irrational_continued_fraction.sv -----
// Top level: continued fraction expansion of (P + sqrt(D)) / Q.
// Setup runs two integer roots, two divides and, when needed, the scaling
//   multiplies; each term then runs a 64-bit and a 32-bit divide on the shared
//   divider plus a search over the k stored pairs.
// Throughput: one item at a time; each result is held until m_tready.
// Reset: rst (synchronous, active high) returns the sequencer to idle and
//   drops m_tvalid; the pair and term memories are not cleared.
`default_nettype none
module quadratic_irrational_continued_fraction #(
  parameter int MAX_TERMS = qicf_pkg::MAX_TERMS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          s_tvalid,
  output logic                         s_tready,
  input  wire  [qicf_pkg::IN_W-1:0]    s_tdata,   // rat_num[15:0], rat_den[31:16], radicand[55:32]
  output logic                         m_tvalid,
  input  wire                          m_tready,
  output logic [qicf_pkg::OUT_W-1:0]   m_tdata,   // quotient[31:0], term_index[38:32], period_start[45:39], zero pad
  output logic [qicf_pkg::ST_W-1:0]    m_tuser,   // status[1:0]
  output logic                         m_tlast
);

  localparam int AW  = $clog2(MAX_TERMS);
  localparam int IW  = qicf_pkg::IDX_W;
  localparam int RW  = qicf_pkg::ROOT_W;
  localparam int DW  = qicf_pkg::RAD_W;

  // sequencer codes
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_SQ1  = 5'd1;   // isqrt of raw radicand
  localparam logic [4:0] S_P0   = 5'd2;   // square check, P*P
  localparam logic [4:0] S_X0   = 5'd3;   // start (D - P*P) / Q
  localparam logic [4:0] S_DV0  = 5'd4;
  localparam logic [4:0] S_SC0  = 5'd5;   // scaling decision, Q*Q
  localparam logic [4:0] S_SC1  = 5'd6;   // D*Q*Q
  localparam logic [4:0] S_SC2  = 5'd7;   // P*|Q|
  localparam logic [4:0] S_SC3  = 5'd8;   // Q*|Q|
  localparam logic [4:0] S_SC4  = 5'd9;
  localparam logic [4:0] S_SQ2  = 5'd10;  // isqrt of radicand, scaled if scaling ran
  localparam logic [4:0] S_A0   = 5'd11;
  localparam logic [4:0] S_AS   = 5'd12;  // start floor((P+s)/Q)
  localparam logic [4:0] S_DVA  = 5'd13;
  localparam logic [4:0] S_AD   = 5'd14;
  localparam logic [4:0] S_T0   = 5'd15;
  localparam logic [4:0] S_ST   = 5'd16;  // store pair, a*Q
  localparam logic [4:0] S_N1   = 5'd17;
  localparam logic [4:0] S_N2   = 5'd18;
  localparam logic [4:0] S_N3   = 5'd19;
  localparam logic [4:0] S_DVQ  = 5'd20;
  localparam logic [4:0] S_N4   = 5'd21;
  localparam logic [4:0] S_SR1  = 5'd22;
  localparam logic [4:0] S_SR2  = 5'd23;
  localparam logic [4:0] S_ERD  = 5'd24;
  localparam logic [4:0] S_ELD  = 5'd25;
  localparam logic [4:0] S_EWT  = 5'd26;

  logic [4:0] state;
  logic       in_loop;

  // working values
  logic signed [31:0] p, q, a;
  logic [DW-1:0]      d;
  logic [RW-1:0]      s;
  logic [IW-1:0]      count, nterms, rd_idx, k, start;

  // shared multiplier, registered product
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  // shared restoring divider on magnitudes
  logic               div_start, div_short, div_floor;
  logic signed [63:0] div_num;
  logic signed [31:0] div_den;
  logic [63:0]        div_num_mag, dquo;
  logic [31:0]        div_den_mag, drem, dden;
  logic [5:0]         dcnt;
  logic               dneg, dzero, dfl;
  logic [32:0]        drem_sh;
  logic               dge;
  logic [31:0]        tres, fres, qmag;

  // shared isqrt unit, two bits per step
  logic               sq_start;
  logic [DW-1:0]      sq_in, sq_src;
  logic [RW-1:0]      sq_r;
  logic [29:0]        sq_rem;
  logic [4:0]         sq_cnt;
  logic [31:0]        sq_rem_sh, sq_trial;
  logic               sq_ge;

  // memories
  logic [63:0] seen [MAX_TERMS];
  logic [31:0] terms [MAX_TERMS];
  logic [63:0] seen_q;
  logic [31:0] term_q;
  logic        term_we;
  logic [AW-1:0] term_wa;

  // output register
  logic [31:0]              out_quot;
  logic [IW-1:0]            out_idx, out_start;
  logic [qicf_pkg::ST_W-1:0] out_status;
  logic                     out_last, out_valid;

  logic signed [31:0] absq, a_num_hi;
  logic               q_pos, pair_hit, at_max;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_start, out_idx, out_quot};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  assign absq     = q[31] ? -q : q;
  assign q_pos    = !q[31] && (q != 32'sd0);
  assign pair_hit = (seen_q == {p, q});
  assign at_max   = (nterms >= IW'(MAX_TERMS));
  assign a_num_hi = 32'sd0;

  // operand selection for the multiplier, divider and root unit
  always_comb begin
    mul_a     = 32'sd0;
    mul_b     = 32'sd0;
    div_start = 1'b0;
    div_short = 1'b1;
    div_floor = 1'b0;
    div_num   = 64'sd0;
    div_den   = q;
    sq_start  = 1'b0;
    sq_in     = d;
    unique case (state)
      S_IDLE: begin
        sq_start = s_tvalid && (s_tdata[31:16] != 16'd0);
        sq_in    = DW'(s_tdata[55:32]);
      end
      S_P0: begin
        mul_a = p;
        mul_b = p;
      end
      S_X0: begin
        div_start = 1'b1;
        div_num   = $signed({8'd0, d}) - prod;
      end
      S_SC0: begin
        mul_a    = q;
        mul_b    = q;
        sq_start = (drem == 32'd0);
      end
      S_SC1: begin
        mul_a = $signed({8'd0, d[23:0]});
        mul_b = prod[31:0];
      end
      S_SC2: begin
        mul_a = p;
        mul_b = absq;
      end
      S_SC3: begin
        mul_a = q;
        mul_b = absq;
      end
      S_SC4: begin
        sq_start = 1'b1;
        sq_in    = d;
      end
      S_AS: begin
        div_start = 1'b1;
        div_floor = 1'b1;
        div_num   = 64'(p) + $signed({36'd0, s}) + (q_pos ? 64'sd0 : 64'sd1);
      end
      S_ST: begin
        mul_a = a;
        mul_b = q;
      end
      S_N2: begin
        mul_a = p;
        mul_b = p;
      end
      S_N3: begin
        div_start = 1'b1;
        div_short = 1'b0;
        div_num   = $signed({8'd0, d}) - prod;
      end
      default: begin
        mul_a = a_num_hi;
      end
    endcase
  end

  assign div_num_mag = div_num[63] ? 64'(-div_num) : 64'(div_num);
  assign div_den_mag = div_den[31] ? 32'(-div_den) : 32'(div_den);

  assign drem_sh = {drem, dquo[63]};
  assign dge     = (drem_sh >= {1'b0, dden});
  assign qmag    = dquo[31:0];
  assign tres    = dzero ? 32'd0 : (dneg ? -qmag : qmag);
  assign fres    = dzero ? 32'd0 :
                   (dneg ? ((dfl && (drem != 32'd0)) ? ~qmag : -qmag) : qmag);

  assign sq_rem_sh = {sq_rem, sq_src[DW-1:DW-2]};
  assign sq_trial  = {2'b00, sq_r, 2'b01};
  assign sq_ge     = (sq_rem_sh >= sq_trial);

  // datapath units
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (div_start) begin
      dquo  <= div_short ? {div_num_mag[31:0], 32'd0} : div_num_mag;
      drem  <= 32'd0;
      dden  <= div_den_mag;
      dcnt  <= div_short ? 6'd31 : 6'd63;
      dneg  <= div_num[63] ^ div_den[31];
      dzero <= (div_den == 32'sd0);
      dfl   <= div_floor;
    end else begin
      dquo <= {dquo[62:0], dge};
      drem <= dge ? 32'(drem_sh - {1'b0, dden}) : drem_sh[31:0];
      dcnt <= dcnt - 6'd1;
    end
    if (sq_start) begin
      sq_src <= sq_in;
      sq_r   <= '0;
      sq_rem <= '0;
      sq_cnt <= 5'(RW - 1);
    end else begin
      sq_src <= {sq_src[DW-3:0], 2'b00};
      sq_r   <= {sq_r[RW-2:0], sq_ge};
      sq_rem <= sq_ge ? 30'(sq_rem_sh - sq_trial) : sq_rem_sh[29:0];
      sq_cnt <= sq_cnt - 5'd1;
    end
  end

  // pair and term memories, registered reads
  assign term_we = (state == S_T0) || ((state == S_SR2) && !pair_hit &&
                   (rd_idx == count) && !at_max);
  assign term_wa = (state == S_T0) ? '0 : nterms[AW-1:0];

  always_ff @(posedge clk) begin
    if (state == S_ST) seen[count[AW-1:0]] <= {p, q};
    if (term_we) terms[term_wa] <= a;
    seen_q <= seen[rd_idx[AW-1:0]];
    term_q <= terms[k[AW-1:0]];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_loop   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            p       <= 32'($signed(s_tdata[15:0]));
            q       <= 32'($signed(s_tdata[31:16]));
            d       <= DW'(s_tdata[55:32]);
            in_loop <= 1'b0;
            if (s_tdata[31:16] == 16'd0) begin
              out_quot   <= '0;
              out_idx    <= '0;
              out_start  <= '0;
              out_status <= qicf_pkg::STAT_ZERO_DEN;
              out_last   <= 1'b1;
              out_valid  <= 1'b1;
              state      <= S_EWT;
            end else begin
              state <= S_SQ1;
            end
          end
        end
        S_SQ1:  if (sq_cnt == 5'd0) state <= S_P0;
        S_P0: begin
          if (sq_rem == 30'd0) begin
            out_quot   <= '0;
            out_idx    <= '0;
            out_start  <= '0;
            out_status <= qicf_pkg::STAT_BAD_RAD;
            out_last   <= 1'b1;
            out_valid  <= 1'b1;
            state      <= S_EWT;
          end else begin
            state <= S_X0;
          end
        end
        S_X0:   state <= S_DV0;
        S_DV0:  if (dcnt == 6'd0) state <= S_SC0;
        S_SC0:  state <= (drem == 32'd0) ? S_SQ2 : S_SC1;
        S_SC1:  state <= S_SC2;
        S_SC2: begin
          d     <= prod[DW-1:0];
          state <= S_SC3;
        end
        S_SC3: begin
          p     <= prod[31:0];
          state <= S_SC4;
        end
        S_SC4: begin
          q     <= prod[31:0];
          state <= S_SQ2;
        end
        S_SQ2:  if (sq_cnt == 5'd0) state <= S_A0;
        S_A0: begin
          s     <= sq_r;
          state <= S_AS;
        end
        S_AS:   state <= S_DVA;
        S_DVA:  if (dcnt == 6'd0) state <= S_AD;
        S_AD: begin
          a      <= fres;
          rd_idx <= '0;
          state  <= in_loop ? S_SR1 : S_T0;
        end
        S_T0: begin
          nterms  <= IW'(1);
          count   <= '0;
          in_loop <= 1'b1;
          state   <= S_ST;
        end
        S_ST: begin
          count <= count + IW'(1);
          state <= S_N1;
        end
        S_N1: begin
          p     <= prod[31:0] - p;
          state <= S_N2;
        end
        S_N2:   state <= S_N3;
        S_N3:   state <= S_DVQ;
        S_DVQ:  if (dcnt == 6'd0) state <= S_N4;
        S_N4: begin
          q     <= tres;
          state <= S_AS;
        end
        S_SR1: begin
          rd_idx <= rd_idx + IW'(1);
          state  <= S_SR2;
        end
        S_SR2: begin
          if (pair_hit) begin
            start <= rd_idx - IW'(1);
            k     <= '0;
            state <= S_ERD;
          end else if (rd_idx == count) begin
            if (at_max) begin
              out_quot   <= '0;
              out_idx    <= '0;
              out_start  <= '0;
              out_status <= qicf_pkg::STAT_OVERFLOW;
              out_last   <= 1'b1;
              out_valid  <= 1'b1;
              state      <= S_EWT;
            end else begin
              nterms <= nterms + IW'(1);
              state  <= S_ST;
            end
          end else begin
            rd_idx <= rd_idx + IW'(1);
          end
        end
        S_ERD:  state <= S_ELD;
        S_ELD: begin
          out_quot   <= term_q;
          out_idx    <= k;
          out_last   <= (k + IW'(1) == nterms);
          out_start  <= (k + IW'(1) == nterms) ? start : '0;
          out_status <= qicf_pkg::STAT_OK;
          out_valid  <= 1'b1;
          state      <= S_EWT;
        end
        S_EWT: begin
          if (m_tready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state <= S_IDLE;
            end else begin
              k     <= k + IW'(1);
              state <= S_ERD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // one item at a time: never ready for input while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while result pending");

  // error results are single transfers at index zero
  a_err_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != qicf_pkg::STAT_OK)) |-> (m_tlast && (m_tdata[38:32] == 7'd0)))
    else $error("error result not a lone final transfer");

  // reset drops the result valid
  a_rst_valid: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");
`endif

endmodule
`default_nettype wire
